@@ hdl/i2c_sensor_scan_sequencer_defines.svh @@
// assertion macros for the i2c sensor scan sequencer
`ifndef I2C_SENSOR_SCAN_SEQUENCER_DEFINES_SVH
`define I2C_SENSOR_SCAN_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ISCAN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ISCAN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/iscan_pkg.sv @@
// types, constants and codes shared by the scan sequencer modules
`default_nettype none

package iscan_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic        bus_error;
    logic [3:0]  error_code;
    logic [47:0] rx_bytes;
    logic [3:0]  reg_offset;
  } in_item_t;

  typedef struct packed {
    logic        req_valid;
    logic [6:0]  dev_address;
    logic        req_is_read;
    logic [2:0]  req_length;
    logic [31:0] tx_bytes;
    logic [15:0] reg_data;
  } out_item_t;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_DONE  = 2'd1;
  localparam logic [1:0] MODE_HOST  = 2'd2;

  typedef enum logic [1:0] {
    ACT_CFG    = 2'd0,
    ACT_POLL   = 2'd1,
    ACT_PTR    = 2'd2,
    ACT_RESULT = 2'd3
  } act_t;

  typedef struct packed {
    logic conv;
    logic ch;
    act_t act;
  } step_t;

  typedef enum logic [1:0] {
    HSEL_NONE,
    HSEL_WORD,
    HSEL_STATUS
  } hsel_t;

  // cache ram: entry 0 holds current, voltage, voltage2, count (msb first)
  // entry 1 holds zero, channel one, channel two, poll count
  localparam int CACHE_W     = 64;
  localparam int CACHE_DEPTH = 2;
  localparam logic ENTRY_MON  = 1'b0;
  localparam logic ENTRY_CONV = 1'b1;

  typedef struct packed {
    out_item_t   req;
    logic        rd_en;
    logic        rd_addr;
    hsel_t       host_sel;
    logic [1:0]  host_lane;
    logic [7:0]  status;
    logic        wr_full;
    logic        wr_result;
    logic        wr_ch;
    logic [63:0] wr_data;
    logic [15:0] wr_word;
    logic [15:0] wr_poll;
  } mem_op_t;

  localparam logic [2:0] CFG_ENABLED  = 3'd0;
  localparam logic [2:0] CFG_MON_ADDR = 3'd1;
  localparam logic [2:0] CFG_CONV_ADDR = 3'd2;
  localparam logic [2:0] CFG_CH1      = 3'd3;
  localparam logic [2:0] CFG_CH2      = 3'd4;

  localparam logic        ENABLED_RST   = 1'b1;
  localparam logic [6:0]  MON_ADDR_RST  = 7'h67;
  localparam logic [6:0]  CONV_ADDR_RST = 7'h48;
  localparam logic [15:0] CH1_CFG_RST   = 16'h8303;
  localparam logic [15:0] CH2_CFG_RST   = 16'hB303;

  localparam logic [2:0] MON_RD_LEN = 3'd6;
  localparam logic [2:0] CFG_WR_LEN = 3'd4;
  localparam logic [2:0] PTR_WR_LEN = 3'd1;
  localparam logic [2:0] RES_RD_LEN = 3'd2;
  localparam logic [7:0] CFG_REG_PTR = 8'h01;

  localparam logic [3:0] OFF_FIRST  = 4'd1;
  localparam logic [3:0] OFF_COUNT  = 4'd4;
  localparam logic [3:0] OFF_STATUS = 4'd5;
  localparam logic [3:0] OFF_LAST   = 4'd8;

  localparam logic [7:0] STAT_ISSUE = 8'h00;
  localparam logic [7:0] STAT_DONE  = 8'h10;
  localparam logic [3:0] STAT_ERR   = 4'h1;

endpackage

`default_nettype wire

@@ hdl/iscan_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none

module iscan_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output      logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/iscan_ctrl.sv @@
// sequencer control: config registers, job state, request generation
`default_nettype none

module iscan_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  input  wire iscan_pkg::in_item_t in_data,
  input  wire logic                cfg_valid,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  output      iscan_pkg::mem_op_t  op
);

  typedef struct packed {
    logic [4:0]  marks;
    logic [15:0] count;
    logic [3:0]  err_code;
    logic [7:0]  status;
  } svc_t;

  // pending host-read marks: clear count after offsets 1-4, clear error on status
  function automatic svc_t service(input svc_t cur, input logic done);
    svc_t r;
    r = cur;
    if (r.marks[3:0] == 4'hF) begin
      r.count      = '0;
      r.marks[3:0] = 4'h0;
    end
    if (r.marks[4]) begin
      r.err_code = '0;
      r.status   = done ? iscan_pkg::STAT_DONE : iscan_pkg::STAT_ISSUE;
      r.marks[4] = 1'b0;
    end
    return r;
  endfunction

  logic                 enabled_r;
  logic [6:0]           mon_addr_r;
  logic [6:0]           conv_addr_r;
  logic [15:0]          ch1_cfg_r;
  logic [15:0]          ch2_cfg_r;
  iscan_pkg::step_t     step_r, step_nxt;
  logic                 held_r, held_nxt;
  logic [15:0]          poll_r, poll_nxt;
  logic                 pend_r, pend_nxt;
  svc_t                 sv_r, sv_nxt;

  always_comb begin : step_logic
    svc_t             sv;
    iscan_pkg::step_t st;
    logic             held;
    logic             pend;
    logic [15:0]      poll;
    logic [2:0]       mark_idx;
    logic [15:0]      cfg;

    sv       = sv_r;
    st       = step_r;
    held     = held_r;
    pend     = pend_r;
    poll     = poll_r;
    mark_idx = 3'(in_data.reg_offset - iscan_pkg::OFF_FIRST);
    cfg      = '0;
    op       = '0;
    op.status = sv_r.status;

    case (in_data.mode)
      iscan_pkg::MODE_HOST: begin
        if (in_data.reg_offset >= iscan_pkg::OFF_FIRST &&
            in_data.reg_offset <= iscan_pkg::OFF_LAST) begin
          if (in_data.reg_offset <= iscan_pkg::OFF_STATUS) begin
            sv.marks = sv_r.marks | 5'(5'd1 << mark_idx);
          end
          if (in_data.reg_offset <= iscan_pkg::OFF_COUNT) begin
            op.host_sel  = iscan_pkg::HSEL_WORD;
            op.rd_en     = 1'b1;
            op.rd_addr   = iscan_pkg::ENTRY_MON;
            op.host_lane = 2'(iscan_pkg::OFF_COUNT - in_data.reg_offset);
          end else if (in_data.reg_offset == iscan_pkg::OFF_STATUS) begin
            op.host_sel = iscan_pkg::HSEL_STATUS;
          end else begin
            op.host_sel  = iscan_pkg::HSEL_WORD;
            op.rd_en     = 1'b1;
            op.rd_addr   = iscan_pkg::ENTRY_CONV;
            op.host_lane = 2'(iscan_pkg::OFF_LAST - in_data.reg_offset);
          end
        end
      end
      iscan_pkg::MODE_START, iscan_pkg::MODE_DONE: begin
        // completion of the outstanding transfer
        if (in_data.mode == iscan_pkg::MODE_DONE && !held_r) begin
          if (in_data.bus_error) begin
            pend        = 1'b1;
            sv.err_code = in_data.error_code;
          end
          held = 1'b1;
          if (!step_r.conv) begin
            sv = service(sv, 1'b1);
            if (pend) begin
              // sticky error: drop this reading, report it in status
              pend      = 1'b0;
              sv.status = {iscan_pkg::STAT_ERR, sv.err_code};
            end else begin
              sv.count   = sv.count + 16'd1;
              op.wr_full = 1'b1;
              op.wr_data = {in_data.rx_bytes, sv.count};
            end
            st.conv = 1'b1;
          end else begin
            case (step_r.act)
              iscan_pkg::ACT_CFG: begin
                st = '{conv: 1'b0, ch: step_r.ch, act: iscan_pkg::ACT_POLL};
              end
              iscan_pkg::ACT_POLL: begin
                if (in_data.rx_bytes[15]) begin
                  st = '{conv: 1'b0, ch: step_r.ch, act: iscan_pkg::ACT_PTR};
                end else begin
                  poll = poll_r + 16'd1;
                  st   = '{conv: 1'b0, ch: step_r.ch, act: iscan_pkg::ACT_POLL};
                end
              end
              iscan_pkg::ACT_PTR: begin
                st = '{conv: 1'b1, ch: step_r.ch, act: iscan_pkg::ACT_RESULT};
              end
              default: begin
                op.wr_result = 1'b1;
                op.rd_en     = 1'b1;
                op.rd_addr   = iscan_pkg::ENTRY_CONV;
                op.wr_ch     = step_r.ch;
                op.wr_word   = in_data.rx_bytes[15:0];
                op.wr_poll   = poll_r;
                st = '{conv: 1'b0, ch: !step_r.ch, act: iscan_pkg::ACT_CFG};
              end
            endcase
          end
        end
        // issue the request for the current step
        if (enabled_r && held) begin
          op.req.req_valid = 1'b1;
          if (!st.conv) begin
            sv = service(sv, 1'b0);
            op.req.dev_address = mon_addr_r;
            op.req.req_is_read = 1'b1;
            op.req.req_length  = iscan_pkg::MON_RD_LEN;
          end else begin
            op.req.dev_address = conv_addr_r;
            case (st.act)
              iscan_pkg::ACT_CFG: begin
                poll = '0;
                cfg  = st.ch ? ch2_cfg_r : ch1_cfg_r;
                op.req.req_length = iscan_pkg::CFG_WR_LEN;
                op.req.tx_bytes = {iscan_pkg::CFG_REG_PTR, cfg[15:8], 8'h00, cfg[7:0]};
              end
              iscan_pkg::ACT_PTR: begin
                op.req.req_length = iscan_pkg::PTR_WR_LEN;
              end
              default: begin
                op.req.req_is_read = 1'b1;
                op.req.req_length  = iscan_pkg::RES_RD_LEN;
              end
            endcase
          end
          held = 1'b0;
        end
      end
      default: begin
      end
    endcase

    sv_nxt   = sv;
    step_nxt = st;
    held_nxt = held;
    pend_nxt = pend;
    poll_nxt = poll;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= iscan_pkg::ENABLED_RST;
      mon_addr_r  <= iscan_pkg::MON_ADDR_RST;
      conv_addr_r <= iscan_pkg::CONV_ADDR_RST;
      ch1_cfg_r   <= iscan_pkg::CH1_CFG_RST;
      ch2_cfg_r   <= iscan_pkg::CH2_CFG_RST;
      step_r      <= '{conv: 1'b0, ch: 1'b0, act: iscan_pkg::ACT_CFG};
      held_r      <= 1'b1;
      poll_r      <= '0;
      pend_r      <= 1'b0;
      sv_r        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          iscan_pkg::CFG_ENABLED:   enabled_r   <= cfg_data[0];
          iscan_pkg::CFG_MON_ADDR:  mon_addr_r  <= cfg_data[6:0];
          iscan_pkg::CFG_CONV_ADDR: conv_addr_r <= cfg_data[6:0];
          iscan_pkg::CFG_CH1:       ch1_cfg_r   <= cfg_data;
          iscan_pkg::CFG_CH2:       ch2_cfg_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        step_r <= step_nxt;
        held_r <= held_nxt;
        poll_r <= poll_nxt;
        pend_r <= pend_nxt;
        sv_r   <= sv_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/iscan_cache.sv @@
// reading cache: ram read-modify-write stage, forwarding and output register
`default_nettype none

module iscan_cache (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire iscan_pkg::mem_op_t   op,
  input  wire logic                 out_ready,
  output      logic                 in_ready,
  output      logic                 out_valid,
  output      iscan_pkg::out_item_t out_data
);

  iscan_pkg::mem_op_t       s1_op_r;
  logic                     s1_valid_r;
  logic                     fwd_hit_r;
  logic [iscan_pkg::CACHE_W-1:0] fwd_data_r;
  logic                     rd_vld_r;
  logic                     ent_vld_r [iscan_pkg::CACHE_DEPTH];
  logic                     out_valid_r;
  iscan_pkg::out_item_t     out_data_r;

  logic                          s1_adv;
  logic [iscan_pkg::CACHE_W-1:0] ram_rdata;
  logic [iscan_pkg::CACHE_W-1:0] eff_data;
  logic [iscan_pkg::CACHE_W-1:0] res_data;
  logic                          wr_en;
  logic                          wr_addr;
  logic [iscan_pkg::CACHE_W-1:0] wr_data;
  logic [15:0]                   host_word;
  iscan_pkg::out_item_t          s1_result;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  iscan_ram #(
    .WIDTH(iscan_pkg::CACHE_W),
    .DEPTH(iscan_pkg::CACHE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (in_fire && op.rd_en),
    .raddr(op.rd_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    // a write in the cycle of our read is not yet visible in the ram output
    if (fwd_hit_r) begin
      eff_data = fwd_data_r;
    end else if (rd_vld_r) begin
      eff_data = ram_rdata;
    end else begin
      eff_data = '0;
    end

    res_data        = eff_data;
    res_data[63:48] = 16'h0000;
    res_data[15:0]  = s1_op_r.wr_poll;
    if (s1_op_r.wr_ch) begin
      res_data[31:16] = s1_op_r.wr_word;
    end else begin
      res_data[47:32] = s1_op_r.wr_word;
    end

    wr_en   = s1_valid_r && s1_adv && (s1_op_r.wr_full || s1_op_r.wr_result);
    wr_addr = s1_op_r.wr_full ? iscan_pkg::ENTRY_MON : iscan_pkg::ENTRY_CONV;
    wr_data = s1_op_r.wr_full ? s1_op_r.wr_data : res_data;

    host_word = eff_data[{s1_op_r.host_lane, 4'b0000} +: 16];
    s1_result = s1_op_r.req;
    case (s1_op_r.host_sel)
      iscan_pkg::HSEL_WORD:   s1_result.reg_data = host_word;
      iscan_pkg::HSEL_STATUS: s1_result.reg_data = {8'h00, s1_op_r.status};
      default:                s1_result.reg_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
      for (int i = 0; i < iscan_pkg::CACHE_DEPTH; i++) begin
        ent_vld_r[i] <= 1'b0;
      end
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= wr_en && (wr_addr == op.rd_addr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (wr_en) begin
        ent_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= op;
      fwd_data_r <= wr_data;
      rd_vld_r   <= ent_vld_r[op.rd_addr];
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= s1_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hdl/i2c_sensor_scan_sequencer.sv @@
// top level of the i2c sensor scan sequencer
`default_nettype none
`include "i2c_sensor_scan_sequencer_defines.svh"

// Scan sequencer for a power monitor and a two-channel converter on one I2C
// bus. Each input beat is a start request, a bus completion or a host
// register read; each produces exactly one result beat carrying the next
// transfer request (req_valid high) and/or the cached word for a host read.
// One beat is accepted every cycle while results are taken. A result is
// presented from the output register, which is loaded from the ram stage
// when the registered read of the cache ram completes, and it is held there
// until taken. With the output stalled, one beat waits in the ram
// stage and one in the output register, and in_ready stays low until the
// result is taken. Job state lives in flip-flops and is updated at accept;
// the cached readings live in a two-entry ram that is read, merged and
// written back one stage later, with forwarding for back-to-back accesses.
// The cache entries carry valid bits, so the block is ready right after
// reset with no clearing pass. The config port never stalls.

module i2c_sensor_scan_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire iscan_pkg::in_item_t  in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      iscan_pkg::out_item_t out_data,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic               in_fire;
  iscan_pkg::mem_op_t op;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  iscan_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .op       (op)
  );

  iscan_cache u_cache (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .op       (op),
    .out_ready(out_ready),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  `ISCAN_ASSERT_IMP(a_host_no_req, out_valid && out_data.reg_data != 16'h0000, !out_data.req_valid, "host read beat also carries a request")
  `ISCAN_ASSERT_IMP(a_idle_req_zero, out_valid && !out_data.req_valid, out_data.req_length == 3'd0 && out_data.tx_bytes == 32'h0 && out_data.dev_address == 7'h00, "request fields set without req_valid")
  `ISCAN_ASSERT_IMP(a_tx_cfg_only, out_valid && out_data.tx_bytes != 32'h0, !out_data.req_is_read && out_data.req_length == iscan_pkg::CFG_WR_LEN, "tx bytes on a transfer other than config write")
  `ISCAN_ASSERT_NXT(a_latency, in_valid && in_ready ##1 out_ready, out_valid, "accepted beat did not reach the output in two cycles")

endmodule

`default_nettype wire
